[design/alp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package alp_pkg;

    // Microphone sample width; bits at or above it are dropped
    localparam int MIC_BITS = 16;
    localparam logic [15:0] MIC_MASK = 16'((32'd1 << MIC_BITS) - 32'd1);

    // Stream payload widths (whole bytes)
    localparam int IN_W  = 72;
    localparam int OUT_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUELCH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_DELAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd6;

    // Register reset values
    localparam logic [7:0]  RST_SQUELCH    = 8'd10;
    localparam logic [7:0]  RST_GAIN       = 8'd40;
    localparam logic [7:0]  RST_TARGET     = 8'd60;
    localparam logic [7:0]  RST_THRESHOLD  = 8'd10;
    localparam logic [8:0]  RST_WEIGHT     = 9'd51;
    localparam logic [15:0] RST_SHOW_DELAY = 16'd15;
    localparam logic [15:0] RST_HOLDOFF    = 16'd100;

    // Arithmetic constants
    localparam logic [8:0]  WEIGHT_ONE = 9'd256;
    localparam logic [15:0] AVG_ONE    = 16'd256;
    localparam logic [7:0]  LEVEL_MAX  = 8'd255;

    // Divide by 40: drop 3 bits, then multiply by ceil(2^23/5) and keep
    // bits 23 up; exact for any 21-bit value after the shift
    localparam logic [20:0] GAIN_RECIP = 21'd1677722;

    // Serial divider sizes
    localparam int DIV_W     = 24;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic [7:0]  squelch;
        logic [7:0]  gain;
        logic [7:0]  target_level;
        logic [7:0]  peak_threshold;
        logic [8:0]  smoothing_weight;
        logic [15:0] show_delay;
        logic [15:0] peak_holdoff;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DC,
        S_DEV,
        S_FILT_MUL,
        S_FILT_SUM,
        S_SQUELCH,
        S_GAIN,
        S_GAIN_SCALE,
        S_AVG,
        S_AGC,
        S_AGC_WAIT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

[design/audio_level_agc_peak.sv]
`timescale 1ns / 1ps
`default_nettype none

// Microphone level, AGC and peak detector.
// Input stream: one transfer per microphone sample with the bin level, the
// time in ms and the two clear flags. Output stream: one transfer per input
// with the sample level, average, AGC level, average times four and flags.
// Configuration: index/data write channel, ready whenever out of reset;
// write only while the block is idle.
// Each sample is worked through by a sequencer around one 24-step serial
// divider used for the AGC division; the gain division by 40 is a reciprocal
// multiply. The divider is used only when the running average is at or
// above one. Input ready rises with output valid and is low while a sample
// is being worked through, so the next sample is taken only once the last
// has left the sequencer.
// The output register holds a finished result until it is taken; the next
// sample can be accepted while it waits, but that sample's result waits in
// its final step until the output register is free.
// Reset (synchronous, active low) clears all filter state and flags and
// loads the register defaults; input ready is low during reset.
module audio_level_agc_peak (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: mic_level[15:0], bin_level[31:16], now_ms[63:32],
    //        consumer_cleared[64], sync_taken[65], zero fill
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [alp_pkg::IN_W-1:0]         i_s_axis_tdata,
    // tdata: sample_level[7:0], average_level[15:8], agc_level[23:16],
    //        average_times_four[31:24], peak[32], sync_peak[33], zero fill
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [alp_pkg::OUT_W-1:0]             o_m_axis_tdata,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [alp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [alp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    alp_pkg::t_cfg     cfg;
    alp_pkg::t_div_req div_req;
    alp_pkg::t_div_rsp div_rsp;
    alp_pkg::t_state   r_state;
    alp_pkg::t_state   n_state;

    // latched input item
    logic [15:0] r_mic;
    logic [15:0] r_bin;
    logic [31:0] r_now;
    logic        r_cons_clr;
    logic        r_sync_clr;

    // filter state (Q16.8 / Q8.8) and working registers
    logic [23:0] r_dc;
    logic [23:0] r_filt;
    logic [15:0] r_avg;
    logic [15:0] r_dev;
    logic [31:0] r_acc;
    logic [7:0]  r_sample;
    logic [7:0]  r_agc;

    // peak flags
    logic        r_peak;
    logic        r_sync_peak;
    logic        r_consumer;
    logic [31:0] r_last_peak;
    logic        n_peak;
    logic        n_sync_peak;
    logic        n_consumer;
    logic [31:0] n_last_peak;

    // output register
    logic                     r_out_valid;
    logic [alp_pkg::OUT_W-1:0] r_out_data;

    logic in_xfer;
    logic out_free;
    logic out_load;

    alp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    alp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Datapath terms
    // ---------------------------------------------------------------
    logic [23:0] mic_q;
    logic [28:0] dc_sum;
    logic [23:0] dev_full;
    logic [8:0]  w_sat;
    logic [8:0]  w_inv;
    logic [23:0] filt_new;
    logic        above_squelch;
    logic [23:0] gain_prod;
    logic [41:0] gain_recip;
    logic [19:0] gain_sum;
    logic [19:0] avg_sum;
    logic [15:0] agc_prod;
    logic [9:0]  avg4_full;
    logic [7:0]  avg4;

    always_comb begin
        mic_q         = {r_mic, 8'b0};
        // dc*31 + mic*256, then /32 by the slice
        dc_sum        = {r_dc, 5'b0} - {5'b0, r_dc} + {5'b0, mic_q};
        dev_full      = (mic_q >= r_dc) ? (mic_q - r_dc) : (r_dc - mic_q);
        w_sat         = (cfg.smoothing_weight > alp_pkg::WEIGHT_ONE)
                        ? alp_pkg::WEIGHT_ONE : cfg.smoothing_weight;
        w_inv         = alp_pkg::WEIGHT_ONE - w_sat;
        filt_new      = r_acc[31:8];
        above_squelch = (filt_new > {8'b0, cfg.squelch, 8'b0});
        gain_prod     = {8'b0, r_filt[23:8]} * {16'b0, cfg.gain};
        // registered product /8, then times the reciprocal of 5
        gain_recip    = {21'b0, r_acc[23:3]} * {21'b0, alp_pkg::GAIN_RECIP};
        gain_sum      = {1'b0, gain_recip[41:23]} + {8'b0, r_filt[23:12]};
        avg_sum       = {r_avg, 4'b0} - {4'b0, r_avg} + {4'b0, r_sample, 8'b0};
        agc_prod      = {8'b0, r_sample} * {8'b0, cfg.target_level};
        avg4_full     = r_avg[15:6];
        avg4          = (avg4_full > {2'b0, alp_pkg::LEVEL_MAX})
                        ? alp_pkg::LEVEL_MAX : avg4_full[7:0];
    end

    // peak flag update for the current item
    logic [31:0] since_peak;

    always_comb begin
        since_peak  = r_now - r_last_peak;
        n_peak      = r_peak;
        n_sync_peak = r_sync_peak;
        n_consumer  = r_consumer;
        n_last_peak = r_last_peak;
        if (since_peak > {16'b0, cfg.show_delay}) begin
            n_peak      = 1'b0;
            n_sync_peak = 1'b0;
        end
        if (r_sync_clr) begin
            n_sync_peak = 1'b0;
        end
        if (r_cons_clr) begin
            n_consumer = 1'b0;
        end
        if (!n_consumer) begin
            n_peak = 1'b0;
        end
        if ((r_bin > {8'b0, cfg.peak_threshold}) &&
            (since_peak > {16'b0, cfg.peak_holdoff})) begin
            n_peak      = 1'b1;
            n_sync_peak = 1'b1;
            n_consumer  = 1'b1;
            n_last_peak = r_now;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            alp_pkg::S_IDLE:       if (in_xfer) n_state = alp_pkg::S_DC;
            alp_pkg::S_DC:         n_state = alp_pkg::S_DEV;
            alp_pkg::S_DEV:        n_state = alp_pkg::S_FILT_MUL;
            alp_pkg::S_FILT_MUL:   n_state = alp_pkg::S_FILT_SUM;
            alp_pkg::S_FILT_SUM:   n_state = alp_pkg::S_SQUELCH;
            alp_pkg::S_SQUELCH:    n_state = alp_pkg::S_GAIN;
            alp_pkg::S_GAIN:       n_state = alp_pkg::S_GAIN_SCALE;
            alp_pkg::S_GAIN_SCALE: n_state = alp_pkg::S_AVG;
            alp_pkg::S_AVG:        n_state = alp_pkg::S_AGC;
            alp_pkg::S_AGC: begin
                if (r_avg < alp_pkg::AVG_ONE) n_state = alp_pkg::S_EMIT;
                else                          n_state = alp_pkg::S_AGC_WAIT;
            end
            alp_pkg::S_AGC_WAIT:   if (div_rsp.done) n_state = alp_pkg::S_EMIT;
            alp_pkg::S_EMIT:       if (out_free) n_state = alp_pkg::S_IDLE;
            default:               n_state = alp_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb begin
        o_s_axis_tready  = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {agc_prod, 8'b0};
        div_req.divisor  = r_avg;
        case (r_state)
            alp_pkg::S_IDLE: o_s_axis_tready = i_rst_n;
            alp_pkg::S_AGC:  div_req.start = (r_avg >= alp_pkg::AVG_ONE);
            alp_pkg::S_EMIT: out_load = out_free;
            default: ;
        endcase
    end

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latched item payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mic      <= i_s_axis_tdata[15:0] & alp_pkg::MIC_MASK;
            r_bin      <= i_s_axis_tdata[31:16];
            r_now      <= i_s_axis_tdata[63:32];
            r_cons_clr <= i_s_axis_tdata[64];
            r_sync_clr <= i_s_axis_tdata[65];
        end
    end

    // filter state and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc        <= '0;
            r_filt      <= '0;
            r_avg       <= '0;
            r_peak      <= 1'b0;
            r_sync_peak <= 1'b0;
            r_consumer  <= 1'b0;
            r_last_peak <= '0;
        end else begin
            case (r_state)
                alp_pkg::S_DC: begin
                    r_dc        <= dc_sum[28:5];
                    r_peak      <= n_peak;
                    r_sync_peak <= n_sync_peak;
                    r_consumer  <= n_consumer;
                    r_last_peak <= n_last_peak;
                end
                alp_pkg::S_SQUELCH: r_filt <= above_squelch ? filt_new : '0;
                alp_pkg::S_AVG:     r_avg  <= avg_sum[19:4];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            alp_pkg::S_DEV:      r_dev <= dev_full[23:8];
            alp_pkg::S_FILT_MUL: r_acc <= {23'b0, w_sat} * {8'b0, r_dev, 8'b0};
            alp_pkg::S_FILT_SUM: r_acc <= r_acc + ({23'b0, w_inv} * {8'b0, r_filt});
            alp_pkg::S_GAIN:     r_acc <= {8'b0, gain_prod};
            alp_pkg::S_GAIN_SCALE: begin
                r_sample <= (gain_sum > 20'(alp_pkg::LEVEL_MAX))
                            ? alp_pkg::LEVEL_MAX : gain_sum[7:0];
            end
            alp_pkg::S_AGC: begin
                if (r_avg < alp_pkg::AVG_ONE) begin
                    r_agc <= (agc_prod > 16'(alp_pkg::LEVEL_MAX)) ? '0 : agc_prod[7:0];
                end
            end
            alp_pkg::S_AGC_WAIT: begin
                if (div_rsp.done) begin
                    r_agc <= (div_rsp.quotient > 24'(alp_pkg::LEVEL_MAX))
                             ? '0 : div_rsp.quotient[7:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {6'b0, r_sync_peak, r_peak, avg4, r_agc, r_avg[15:8], r_sample};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == alp_pkg::S_DC))
        else $error("accepted item did not start the sequence");

    a_squelch_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alp_pkg::S_GAIN) |->
            ((r_filt == '0) || (r_filt[23:8] >= {8'b0, cfg.squelch})))
        else $error("filtered level below squelch floor");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

[design/alp_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module alp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [alp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [alp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output alp_pkg::t_cfg                        o_cfg
);

    alp_pkg::t_cfg r_cfg;

    // writes are taken whenever out of reset
    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.squelch          <= alp_pkg::RST_SQUELCH;
            r_cfg.gain             <= alp_pkg::RST_GAIN;
            r_cfg.target_level     <= alp_pkg::RST_TARGET;
            r_cfg.peak_threshold   <= alp_pkg::RST_THRESHOLD;
            r_cfg.smoothing_weight <= alp_pkg::RST_WEIGHT;
            r_cfg.show_delay       <= alp_pkg::RST_SHOW_DELAY;
            r_cfg.peak_holdoff     <= alp_pkg::RST_HOLDOFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                alp_pkg::CFG_SQUELCH:    r_cfg.squelch          <= i_cfg_data[7:0];
                alp_pkg::CFG_GAIN:       r_cfg.gain             <= i_cfg_data[7:0];
                alp_pkg::CFG_TARGET:     r_cfg.target_level     <= i_cfg_data[7:0];
                alp_pkg::CFG_THRESHOLD:  r_cfg.peak_threshold   <= i_cfg_data[7:0];
                alp_pkg::CFG_WEIGHT:     r_cfg.smoothing_weight <= i_cfg_data[8:0];
                alp_pkg::CFG_SHOW_DELAY: r_cfg.show_delay       <= i_cfg_data;
                alp_pkg::CFG_HOLDOFF:    r_cfg.peak_holdoff     <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/alp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module alp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  alp_pkg::t_div_req i_req,
    output alp_pkg::t_div_rsp o_rsp
);

    logic [alp_pkg::DVS_W-1:0]     r_rem;
    logic [alp_pkg::DIV_W-1:0]     r_quo;
    logic [alp_pkg::DVS_W-1:0]     r_dvs;
    logic [alp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [alp_pkg::DVS_W:0] shifted;
    logic [alp_pkg::DVS_W:0] diff;
    logic                    fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[alp_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == alp_pkg::DIV_CNT_W'(alp_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[alp_pkg::DVS_W-1:0] : shifted[alp_pkg::DVS_W-1:0];
            r_quo <= {r_quo[alp_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[sim/audio_level_agc_peak_tb.sv]
`timescale 1ns / 1ps

module audio_level_agc_peak_tb;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 100;
    localparam int IDLE_PCT         = 13;

    // Index that maps to no register; a write there must change nothing
    localparam logic [alp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [15:0] mic_level;
        logic [15:0] bin_level;
        logic [31:0] now_ms;
        logic        consumer_cleared;
        logic        sync_taken;
    } t_mic_item;

    typedef struct packed {
        logic [7:0] sample_level;
        logic [7:0] average_level;
        logic [7:0] agc_level;
        logic [7:0] average_times_four;
        logic       peak;
        logic       sync_peak;
    } t_levels;

    typedef struct packed {
        logic [7:0]  squelch;
        logic [7:0]  gain;
        logic [7:0]  target;
        logic [7:0]  threshold;
        logic [8:0]  weight;
        logic [15:0] show_delay;
        logic [15:0] holdoff;
    } t_settings;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [alp_pkg::IN_W-1:0]          i_s_axis_tdata = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [alp_pkg::OUT_W-1:0]         o_m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [alp_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [alp_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    // Predictor copy of the registers and the filter / flag state
    t_settings       cfg;
    longint unsigned dc_q;
    longint unsigned filt_q;
    longint unsigned avg_q;
    logic            peak_fx;
    logic            sync_fx;
    logic            consumer_fx;
    logic [31:0]     last_peak_ms;

    t_levels         expected_levels[$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;
    bit              offering = 1'b0;
    bit              src_gaps = 1'b1;
    bit              sink_stalls = 1'b1;
    bit              sink_holding = 1'b0;
    event            sink_hold_ev;
    logic [31:0]     clock_ms = 32'd1000;
    int unsigned     mic_swing = 2000;

    audio_level_agc_peak u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("audio_level_agc_peak_tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic t_settings reset_settings();
        t_settings s;
        s.squelch    = alp_pkg::RST_SQUELCH;
        s.gain       = alp_pkg::RST_GAIN;
        s.target     = alp_pkg::RST_TARGET;
        s.threshold  = alp_pkg::RST_THRESHOLD;
        s.weight     = alp_pkg::RST_WEIGHT;
        s.show_delay = alp_pkg::RST_SHOW_DELAY;
        s.holdoff    = alp_pkg::RST_HOLDOFF;
        return s;
    endfunction

    function automatic t_levels predict_levels(input t_mic_item it);
        longint unsigned mic_q;
        longint unsigned dev;
        longint unsigned w;
        longint unsigned s;
        longint unsigned lvl;
        longint unsigned agc;
        longint unsigned avg4;
        logic [31:0]     since;
        t_levels         r;
        mic_q = longint'(it.mic_level & alp_pkg::MIC_MASK) << 8;

        // DC tracking and magnitude of the deviation (Q16.8)
        dc_q = (dc_q * 31 + mic_q) / 32;
        dev  = (mic_q >= dc_q) ? (mic_q - dc_q) : (dc_q - mic_q);
        dev  = dev >> 8;

        // exponential filter, weight saturates at one
        w = (cfg.weight > 9'd256) ? 256 : longint'(cfg.weight);
        filt_q = (w * (dev << 8) + (256 - w) * filt_q) >> 8;
        if (filt_q <= (longint'(cfg.squelch) << 8))
            filt_q = 0;

        // gain and saturation
        s   = filt_q >> 8;
        lvl = s * longint'(cfg.gain) / 40 + s / 16;
        if (lvl > 255)
            lvl = 255;

        avg_q = (avg_q * 15 + (lvl << 8)) / 16;

        if (avg_q < 256)
            agc = lvl * longint'(cfg.target);
        else
            agc = (lvl * longint'(cfg.target) * 256) / avg_q;
        if (agc > 255)
            agc = 0;

        avg4 = avg_q >> 6;
        if (avg4 > 255)
            avg4 = 255;

        // flag update, all time differences wrap at 32 bits
        since = it.now_ms - last_peak_ms;
        if (since > 32'(cfg.show_delay)) begin
            peak_fx = 1'b0;
            sync_fx = 1'b0;
        end
        if (it.sync_taken)
            sync_fx = 1'b0;
        if (it.consumer_cleared)
            consumer_fx = 1'b0;
        if (!consumer_fx)
            peak_fx = 1'b0;
        if (it.bin_level > 16'(cfg.threshold) && since > 32'(cfg.holdoff)) begin
            peak_fx      = 1'b1;
            sync_fx      = 1'b1;
            consumer_fx  = 1'b1;
            last_peak_ms = it.now_ms;
        end

        r.sample_level       = lvl[7:0];
        r.average_level      = avg_q[15:8];
        r.agc_level          = agc[7:0];
        r.average_times_four = avg4[7:0];
        r.peak               = peak_fx;
        r.sync_peak          = sync_fx;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic check_levels(input logic [alp_pkg::OUT_W-1:0] d);
        t_levels want;
        if (expected_levels.size() == 0) begin
            report_mismatch("result with nothing outstanding", 32'(d[33:0]), 32'd0);
        end else begin
            want = expected_levels.pop_front();
            if (d[7:0] !== want.sample_level)
                report_mismatch("sample_level", 32'(d[7:0]), 32'(want.sample_level));
            if (d[15:8] !== want.average_level)
                report_mismatch("average_level", 32'(d[15:8]), 32'(want.average_level));
            if (d[23:16] !== want.agc_level)
                report_mismatch("agc_level", 32'(d[23:16]), 32'(want.agc_level));
            if (d[31:24] !== want.average_times_four)
                report_mismatch("average_times_four", 32'(d[31:24]),
                                32'(want.average_times_four));
            if (d[32] !== want.peak)
                report_mismatch("peak", 32'(d[32]), 32'(want.peak));
            if (d[33] !== want.sync_peak)
                report_mismatch("sync_peak", 32'(d[33]), 32'(want.sync_peak));
        end
    endtask

    // Result side: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_levels(o_m_axis_tdata);
        i_m_axis_tready <= !sink_holding &&
                           !(sink_stalls && $urandom_range(0, 99) < IDLE_PCT);
    end

    initial begin
        forever begin
            @(sink_hold_ev);
            sink_holding = 1'b1;
            repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
            sink_holding = 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------
    task automatic send_sample(input t_mic_item it);
        int unsigned gap;
        if (src_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 70);
            if (offering) begin
                i_s_axis_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, it.sync_taken, it.consumer_cleared, it.now_ms,
                            it.bin_level, it.mic_level};
        offering = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_levels.push_back(predict_levels(it));
    endtask

    task automatic send_fields(input logic [15:0] mic, input logic [15:0] bin,
                               input logic [31:0] now, input logic cons,
                               input logic sync);
        t_mic_item it;
        it.mic_level        = mic;
        it.bin_level        = bin;
        it.now_ms           = now;
        it.consumer_cleared = cons;
        it.sync_taken       = sync;
        send_sample(it);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        if (offering) begin
            i_s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_levels.size() != 0) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after its last write
    task automatic write_reg(input logic [alp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [alp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            alp_pkg::CFG_SQUELCH:    cfg.squelch    = data[7:0];
            alp_pkg::CFG_GAIN:       cfg.gain       = data[7:0];
            alp_pkg::CFG_TARGET:     cfg.target     = data[7:0];
            alp_pkg::CFG_THRESHOLD:  cfg.threshold  = data[7:0];
            alp_pkg::CFG_WEIGHT:     cfg.weight     = data[8:0];
            alp_pkg::CFG_SHOW_DELAY: cfg.show_delay = data;
            alp_pkg::CFG_HOLDOFF:    cfg.holdoff    = data;
            default: ;
        endcase
    endtask

    // Unused upper data bits carry noise; the block must drop them
    task automatic program_regs(input t_settings s);
        wait_drained();
        write_reg(alp_pkg::CFG_SQUELCH,    {8'($urandom), s.squelch});
        write_reg(alp_pkg::CFG_GAIN,       {8'($urandom), s.gain});
        write_reg(alp_pkg::CFG_TARGET,     {8'($urandom), s.target});
        write_reg(alp_pkg::CFG_THRESHOLD,  {8'($urandom), s.threshold});
        write_reg(alp_pkg::CFG_WEIGHT,     {7'($urandom), s.weight});
        write_reg(alp_pkg::CFG_SHOW_DELAY, s.show_delay);
        write_reg(alp_pkg::CFG_HOLDOFF,    s.holdoff);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------------
    function automatic t_settings rand_settings();
        t_settings s;
        s.squelch    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        s.gain       = 8'($urandom);
        s.target     = 8'($urandom);
        s.threshold  = 8'($urandom);
        s.weight     = 9'($urandom_range(0, 511));
        s.show_delay = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 60));
        s.holdoff    = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 150));
        return s;
    endfunction

    // Audio-like samples around mid scale, with noise, extremes and time jumps
    function automatic t_mic_item rand_item();
        t_mic_item   it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.mic_level = 16'($urandom);
        else if (pick < 12)
            it.mic_level = pick[0] ? 16'hFFFF : 16'h0000;
        else
            it.mic_level = 16'(32'd32768 + $urandom_range(0, 2 * mic_swing) - mic_swing);

        pick = $urandom_range(0, 99);
        if (pick < 50)
            it.bin_level = 16'($urandom_range(0, 300));
        else if (pick < 60)
            it.bin_level = 16'($urandom);
        else if (pick < 65)
            it.bin_level = 16'hFFFF;
        else
            it.bin_level = 16'h0000;

        pick = $urandom_range(0, 99);
        if (pick < 3)
            clock_ms = $urandom;
        else if (pick < 6)
            clock_ms = clock_ms + $urandom_range(100, 70000);
        else
            clock_ms = clock_ms + $urandom_range(0, 12);
        it.now_ms = clock_ms;

        it.consumer_cleared = ($urandom_range(0, 3) == 0);
        it.sync_taken       = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    task automatic run_phase(input t_settings s, input int n_items);
        program_regs(s);
        // a still input lets the average decay towards zero
        mic_swing = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 32767);
        repeat (n_items) send_sample(rand_item());
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Small first sample: average stays under one, low AGC branch
    task automatic test_low_average();
        t_settings s;
        s         = reset_settings();
        s.squelch = 8'd0;
        s.target  = 8'd20;
        program_regs(s);
        send_fields(16'h0030, 16'h0000, 32'd0, 1'b0, 1'b0);
        send_fields(16'h0000, 16'h0000, 32'd0, 1'b0, 1'b0);
    endtask

    // Field extremes, AGC overflow and every way the flags clear
    task automatic test_level_extremes();
        program_regs(reset_settings());
        send_fields(16'hFFFF, 16'hFFFF, 32'd200, 1'b0, 1'b0);
        send_fields(16'h0000, 16'h0000, 32'd205, 1'b0, 1'b0);
        send_fields(16'hFFFF, 16'h0000, 32'd210, 1'b0, 1'b1);
        send_fields(16'h0000, 16'h0000, 32'd212, 1'b1, 1'b0);
        send_fields(16'h8000, 16'hFFFF, 32'd250, 1'b0, 1'b0);
        send_fields(16'h7FFF, 16'd11,   32'd400, 1'b0, 1'b0);
        send_fields(16'h5555, 16'd10,   32'd420, 1'b0, 1'b0);
        send_fields(16'hAAAA, 16'h0000, 32'd421, 1'b1, 1'b1);
    endtask

    // Filter weight of zero, exactly one, and above one (saturates)
    task automatic test_weight_extremes();
        t_settings s;
        s = reset_settings();
        s.weight = 9'd0;
        program_regs(s);
        send_fields(16'hF000, 16'h0000, 32'd500, 1'b0, 1'b0);
        send_fields(16'h0100, 16'h0000, 32'd501, 1'b0, 1'b0);
        s.weight = 9'd256;
        program_regs(s);
        send_fields(16'hF000, 16'h0000, 32'd502, 1'b0, 1'b0);
        send_fields(16'h0100, 16'h0000, 32'd503, 1'b0, 1'b0);
        s.weight = 9'd511;
        program_regs(s);
        send_fields(16'hF000, 16'h0000, 32'd504, 1'b0, 1'b0);
        send_fields(16'h0100, 16'h0000, 32'd505, 1'b0, 1'b0);
    endtask

    // Millisecond counter wrapping through zero
    task automatic test_time_wrap();
        program_regs(reset_settings());
        send_fields(16'h9000, 16'hFFFF, 32'hFFFF_FFF0, 1'b0, 1'b0);
        send_fields(16'h7000, 16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_fields(16'h9000, 16'hFFFF, 32'h0000_0005, 1'b0, 1'b0);
        send_fields(16'h7000, 16'hFFFF, 32'h0000_0070, 1'b0, 1'b0);
    endtask

    // A write to an index with no register must leave the settings alone
    task automatic test_unused_index();
        wait_drained();
        write_reg(CFG_UNUSED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_fields(16'h1234, 16'h00FF, 32'h0000_0200, 1'b1, 1'b0);
        send_fields(16'hEDCB, 16'h0000, 32'h0000_0201, 1'b0, 1'b1);
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        run_phase(rand_settings(), 150);
        wait_drained();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Several settings, the extremes among them
    task automatic test_random_settings();
        t_settings lo;
        t_settings hi;
        lo = '0;
        hi = '{squelch: 8'hFF, gain: 8'hFF, target: 8'hFF, threshold: 8'hFF,
               weight: 9'h1FF, show_delay: 16'hFFFF, holdoff: 16'hFFFF};
        for (int p = 0; p < 8; p++) begin
            if (p == 2)
                run_phase(lo, 110);
            else if (p == 5)
                run_phase(hi, 110);
            else
                run_phase(rand_settings(), 110);
        end
    endtask

    // Receiver holds off while samples keep coming, so the input stalls
    task automatic test_output_stall();
        wait_drained();
        -> sink_hold_ev;
        repeat (30) send_sample(rand_item());
    endtask

    // Sender goes quiet until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (40) send_sample(rand_item());
        wait_drained();
        repeat (40) send_sample(rand_item());
    endtask

    initial begin
        cfg          = reset_settings();
        dc_q         = 0;
        filt_q       = 0;
        avg_q        = 0;
        peak_fx      = 1'b0;
        sync_fx      = 1'b0;
        consumer_fx  = 1'b0;
        last_peak_ms = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_low_average();
        test_level_extremes();
        test_weight_extremes();
        test_time_wrap();
        test_unused_index();
        test_back_to_back();
        test_random_settings();
        test_output_stall();
        test_sender_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("audio_level_agc_peak_tb: PASS");
        else
            $display("audio_level_agc_peak_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
design/alp_pkg.sv
design/alp_cfg.sv
design/alp_div.sv
design/audio_level_agc_peak.sv
sim/audio_level_agc_peak_tb.sv
